### hdl/prk_pkg.sv
// Package for the PageRank power iteration core: sizes, request codes,
// sequencer states and register indexes. No dependencies.
package prk_pkg;

  localparam int MaxNodes = 32;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);
  localparam int RankW    = 18;
  localparam logic [16:0] RankMax = 17'h1FFFF;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_MAX_ITER   = 2'd1,
    REG_DAMPING    = 2'd2,
    REG_TOLERANCE  = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_INIT_DIV,
    S_INIT_DEG,
    S_TELE_DIV,
    S_INIT_RANK,
    S_ROUND,
    S_DANG,
    S_DANG_DIV,
    S_NODE,
    S_EDGE,
    S_EDGE_DIV,
    S_EDGE_MUL,
    S_NODE_END,
    S_DANG_MUL,
    S_DIFF,
    S_COPY,
    S_EMIT
  } state_t;

endpackage

### hdl/prk_if.sv
// Valid/ready channel interfaces for the PageRank core.
// Depends on prk_pkg.
interface prk_req_if import prk_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] from_node;
  logic [5:0] to_node;
  modport source (output valid, req_type, from_node, to_node, input ready);
  modport sink   (input valid, req_type, from_node, to_node, output ready);
endinterface

interface prk_rank_if import prk_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [4:0]  node_index;
  logic [16:0] rank_value;
  logic        converged;
  logic [9:0]  rounds_done;
  logic        last;
  modport source (output valid, node_index, rank_value, converged, rounds_done, last,
                  input ready);
  modport sink   (input valid, node_index, rank_value, converged, rounds_done, last,
                  output ready);
endinterface

### hdl/pagerank_power_iteration_core.sv
// PageRank power iteration core: APB registers, edge loader and run sequencer.
// Depends on prk_pkg, prk_if and prk_divider.
//
// Add-edge and unused requests are taken one per cycle with ready held high;
// a clear sweeps the 32 rows, one per cycle, with ready low. A run is driven
// by one shared serial divider and one 18x16 multiplier: setup first, then
// per round the dangling sum, the node sums (every candidate source is
// scanned and each edge adds a quotient), the L1 change and the copy (the
// copy is skipped when the round converges), and the round test.
// Results then leave one per cycle as the sink takes them. The serial
// divider sets the cost of every quotient.
module pagerank_power_iteration_core import prk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  prk_req_if.sink     req,
  prk_rank_if.source  rank,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [5:0]  node_count;
  logic [9:0]  max_iterations;
  logic [15:0] damping;
  logic [15:0] tolerance;
  reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= 6'd32;
      max_iterations <= 10'd100;
      damping        <= 16'd55706;
      tolerance      <= 16'd66;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_NODE_COUNT: node_count     <= pwdata[5:0];
        REG_MAX_ITER:   max_iterations <= pwdata[9:0];
        REG_DAMPING:    damping        <= pwdata[15:0];
        REG_TOLERANCE:  tolerance      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_COUNT: prdata = {26'd0, node_count};
      REG_MAX_ITER:   prdata = {22'd0, max_iterations};
      REG_DAMPING:    prdata = {16'd0, damping};
      REG_TOLERANCE:  prdata = {16'd0, tolerance};
      default:        prdata = '0;
    endcase
  end

  // Effective node count
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (node_count == 6'd0) n_eff = CntW'(1);
    else if (node_count > 6'(MaxNodes)) n_eff = CntW'(MaxNodes);
    else n_eff = CntW'(node_count);
  end

  // Storage
  logic [MaxNodes-1:0] adj [MaxNodes];
  logic [RankW-1:0]    rank_mem [MaxNodes];
  logic [RankW-1:0]    next_mem [MaxNodes];
  logic [CntW-1:0]     deg [MaxNodes];

  state_t state, state_next;

  logic [IdxW-1:0]  i_idx, j_idx;
  logic [CntW-1:0]  n_run;
  logic [MaxNodes-1:0] mask_run;
  logic [9:0]       iter;
  logic [9:0]       iters_max;
  logic [15:0]      damp_run;
  logic [15:0]      tol_run;
  logic [RankW-1:0] init_rank;
  logic [RankW-1:0] teleport;
  logic [23:0]      dangling;
  logic [23:0]      acc;
  logic [23:0]      diff;
  logic             conv;
  logic             i_last, j_last;

  // Shared divider and multiplier
  logic             div_start, div_done;
  logic [RankW-1:0] div_a, div_q;
  logic [CntW-1:0]  div_b;
  logic [RankW-1:0] mul_a;
  logic [39:0]      mul_p;
  logic [23:0]      mul_res;

  prk_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign i_last = (CntW'(i_idx) == n_run - 1'b1);
  assign j_last = (CntW'(j_idx) == n_run - 1'b1);

  logic [RankW-1:0] r_j, r_i, nx_i;
  assign r_j  = rank_mem[j_idx];
  assign r_i  = rank_mem[i_idx];
  assign nx_i = next_mem[i_idx];

  logic edge_hit;
  assign edge_hit = adj[j_idx][i_idx] && (deg[j_idx] != '0);

  logic [RankW-1:0] absd;
  assign absd = (nx_i > r_i) ? nx_i - r_i : r_i - nx_i;

  logic [23:0] node_sum;
  assign node_sum = acc + 24'(mul_p[39:16]);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) begin
        unique case (req_t'(req.req_type))
          REQ_RUN:   state_next = S_INIT_DIV;
          REQ_CLEAR: state_next = S_CLEAR;
          default:   state_next = S_IDLE;
        endcase
      end
      S_CLEAR:     if (i_idx == IdxW'(MaxNodes - 1)) state_next = S_IDLE;
      S_INIT_DIV:  state_next = S_INIT_DEG;
      S_INIT_DEG:  if (div_done) state_next = S_TELE_DIV;
      S_TELE_DIV:  if (div_done) state_next = S_INIT_RANK;
      S_INIT_RANK: if (i_last) state_next = S_ROUND;
      S_ROUND:     state_next = (iter == iters_max) ? S_EMIT : S_DANG;
      S_DANG:      state_next = S_DANG_DIV;
      S_DANG_DIV:  if (div_done) state_next = j_last ? S_NODE : S_DANG;
      S_NODE:      state_next = S_EDGE;
      S_EDGE:      if (edge_hit) state_next = S_EDGE_DIV;
                   else if (j_last) state_next = S_DANG_MUL;
      S_EDGE_DIV:  if (div_done) state_next = S_EDGE_MUL;
      S_EDGE_MUL:  state_next = j_last ? S_DANG_MUL : S_EDGE;
      S_DANG_MUL:  state_next = S_NODE_END;
      S_NODE_END:  state_next = i_last ? S_DIFF : S_NODE;
      S_DIFF:      if (i_last) state_next = S_COPY;
      S_COPY:      if (conv) state_next = S_EMIT;
                   else if (i_last) state_next = S_ROUND;
      S_EMIT:      if (rank.ready && i_last) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready = (state == S_IDLE);
    rank.valid = (state == S_EMIT);
    rank.node_index  = 5'(i_idx);
    rank.rank_value  = (r_i > 18'(RankMax)) ? RankMax : r_i[16:0];
    rank.converged   = conv;
    rank.rounds_done = iter;
    rank.last        = i_last;
    div_start = 1'b0;
    div_a = '0;
    div_b = n_run;
    mul_a = div_q;
    unique case (state)
      S_INIT_DIV: begin
        div_start = 1'b1;
        div_a = RankW'(65536);
      end
      S_INIT_DEG: begin
        div_start = div_done;
        div_a = RankW'(17'd65536 - {1'b0, damp_run});
      end
      S_DANG: begin
        div_start = 1'b1;
        div_a = r_j;
      end
      S_EDGE: begin
        div_start = edge_hit;
        div_a = r_j;
        div_b = deg[j_idx];
      end
      S_DANG_MUL: mul_a = dangling[RankW-1:0];
      default: ;
    endcase
    mul_p = 40'(mul_a) * 40'(damp_run);
  end
  assign mul_res = node_sum;

  // Datapath and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < MaxNodes; k++) begin
        adj[k] <= '0;
        deg[k] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (req.valid) begin
          i_idx <= '0;
          j_idx <= '0;
          n_run <= n_eff;
          mask_run <= MaxNodes'((33'd1 << n_eff) - 33'd1);
          iters_max <= max_iterations;
          damp_run <= damping;
          tol_run <= tolerance;
          iter <= '0;
          conv <= 1'b0;
          if (req_t'(req.req_type) == REQ_ADD && req.from_node != 6'd0
              && req.to_node != 6'd0 && CntW'(req.from_node) <= n_eff
              && CntW'(req.to_node) <= n_eff) begin
            if (!adj[IdxW'(req.from_node - 6'd1)][IdxW'(req.to_node - 6'd1)]) begin
              adj[IdxW'(req.from_node - 6'd1)][IdxW'(req.to_node - 6'd1)] <= 1'b1;
            end
          end
        end
        S_CLEAR: begin
          adj[i_idx] <= '0;
          i_idx <= i_idx + 1'b1;
        end
        S_INIT_DIV: ;
        S_INIT_DEG: if (div_done) init_rank <= div_q;
        S_TELE_DIV: if (div_done) begin
          teleport <= div_q;
          i_idx <= '0;
        end
        S_INIT_RANK: begin
          rank_mem[i_idx] <= init_rank;
          deg[i_idx] <= CntW'($countones(adj[i_idx] & mask_run));
          i_idx <= i_idx + 1'b1;
        end
        S_ROUND: begin
          dangling <= '0;
          diff <= '0;
          i_idx <= '0;
          j_idx <= '0;
        end
        S_DANG: ;
        S_DANG_DIV: if (div_done) begin
          if (deg[j_idx] == '0) dangling <= dangling + 24'(div_q);
          j_idx <= j_last ? '0 : j_idx + 1'b1;
        end
        S_NODE: begin
          acc <= 24'(teleport);
          j_idx <= '0;
        end
        S_EDGE: if (!edge_hit && !j_last) j_idx <= j_idx + 1'b1;
        S_EDGE_DIV: ;
        S_EDGE_MUL: begin
          acc <= mul_res;
          if (!j_last) j_idx <= j_idx + 1'b1;
        end
        S_DANG_MUL: acc <= mul_res;
        S_NODE_END: begin
          next_mem[i_idx] <= (acc > 24'(RankMax)) ? 18'(RankMax) : acc[RankW-1:0];
          i_idx <= i_last ? '0 : i_idx + 1'b1;
        end
        S_DIFF: begin
          diff <= diff + 24'(absd);
          if (i_last) begin
            iter <= iter + 1'b1;
            conv <= (diff + 24'(absd)) < 24'(tol_run);
          end
          i_idx <= i_last ? '0 : i_idx + 1'b1;
        end
        S_COPY: begin
          if (!conv) rank_mem[i_idx] <= nx_i;
          i_idx <= (i_last || conv) ? '0 : i_idx + 1'b1;
        end
        S_EMIT: if (rank.ready) i_idx <= i_idx + 1'b1;
        default: ;
      endcase
      // degree counts follow edge adds and clears
      if (state == S_IDLE && req.valid && req_t'(req.req_type) == REQ_ADD
          && req.from_node != 6'd0 && req.to_node != 6'd0
          && CntW'(req.from_node) <= n_eff && CntW'(req.to_node) <= n_eff
          && !adj[IdxW'(req.from_node - 6'd1)][IdxW'(req.to_node - 6'd1)])
        deg[IdxW'(req.from_node - 6'd1)] <= deg[IdxW'(req.from_node - 6'd1)] + 1'b1;
      if (state == S_CLEAR) deg[i_idx] <= '0;
    end
  end

endmodule

### hdl/prk_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 18-bit dividend and 6-bit divisor.
// Depends on prk_pkg.
module prk_divider import prk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RankW-1:0] dividend,
  input  logic [CntW-1:0]  divisor,
  output logic             done,
  output logic [RankW-1:0] quotient
);

  localparam int StepW = $clog2(RankW + 1);

  logic [RankW-1:0] quo;
  logic [CntW:0]    rem;
  logic [CntW-1:0]  dvs;
  logic [StepW-1:0] steps;
  logic             busy;
  logic [CntW:0]    trial;

  assign trial    = {rem[CntW-1:0], quo[RankW-1]};
  assign quotient = quo;

  // Shift and subtract, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepW'(RankW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quo <= {quo[RankW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[RankW-2:0], 1'b0};
      end
    end
  end

endmodule
